FILE: hw/rtl/mptm_pkg.sv
// ---------------------------------------------------------------------------
// mptm_pkg
// Shared codes and types for the multi-pattern trie matcher.
// ---------------------------------------------------------------------------
package mptm_pkg;

    localparam logic [2:0] CMD_PATTERN = 3'd0;
    localparam logic [2:0] CMD_SEARCH  = 3'd1;
    localparam logic [2:0] CMD_EOT     = 3'd2;
    localparam logic [2:0] CMD_RESTART = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;

    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_MATCH  = 1'b1;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
    localparam logic [7:0] ASCII_CASE_OFS = 8'h20;

    typedef enum logic [2:0] {
        OP_FIND,
        OP_FINDADD,
        OP_READ,
        OP_SET_TAG,
        OP_SET_BACK,
        OP_CLEAR
    } tok_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KMP_RD,
        S_KMP_CMP,
        S_WALK_RD,
        S_WALK_ISSUE,
        S_WALK_WAIT,
        S_TAG_ISSUE,
        S_BACK_RD1,
        S_BACK_RD2,
        S_BACK_ISSUE,
        S_SRCH_ISSUE,
        S_SRCH_WAIT,
        S_EOT_ISSUE,
        S_EOT_WAIT,
        S_CLR,
        S_EMIT
    } state_t;

endpackage

FILE: hw/rtl/mptm_cell.sv
// ---------------------------------------------------------------------------
// mptm_cell
// One trie node: edge key, tag flag and back link. Acts on the passing
// token, registers it and hands it on to the next cell.
// ---------------------------------------------------------------------------
module mptm_cell
    import mptm_pkg::*;
#(
    parameter int IDX  = 0,
    parameter int IW   = 8,
    parameter int CNTW = 9,
    parameter int CW   = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [CNTW-1:0] node_count,
    input  logic [$bits(tok_op_t)+5*IW+CW+4-1:0] tok_in,
    output logic [$bits(tok_op_t)+5*IW+CW+4-1:0] tok_out
);

    typedef struct packed {
        logic          valid;
        tok_op_t       op;
        logic [IW-1:0] kp;
        logic [CW-1:0] kc;
        logic [IW-1:0] ridx;
        logic [IW-1:0] data;
        logic          found;
        logic          made;
        logic [IW-1:0] fidx;
        logic          ftag;
        logic [IW-1:0] rback;
    } tok_t;

    localparam bit IS_ROOT = (IDX == 0);

    tok_t          tin;
    tok_t          tok_reg;
    tok_t          tok_next;
    logic [IW-1:0] kp_reg;
    logic [IW-1:0] kp_next;
    logic [CW-1:0] kc_reg;
    logic [CW-1:0] kc_next;
    logic          tagged_reg;
    logic          tagged_next;
    logic          bset_reg;
    logic          bset_next;
    logic [IW-1:0] back_reg;
    logic [IW-1:0] back_next;
    logic          live;
    logic          key_hit;
    logic          idx_hit;
    logic          make;

    assign tin     = tok_t'(tok_in);
    assign tok_out = tok_reg;

    always_comb
    begin
        live    = !IS_ROOT && (CNTW'(IDX) < node_count);
        key_hit = tin.valid && live && (tin.op == OP_FIND || tin.op == OP_FINDADD)
                  && kp_reg == tin.kp && kc_reg == tin.kc;
        idx_hit = tin.valid && tin.ridx == IW'(IDX);
        make    = tin.valid && tin.op == OP_FINDADD && !tin.found
                  && node_count == CNTW'(IDX);

        tok_next    = tin;
        kp_next     = kp_reg;
        kc_next     = kc_reg;
        tagged_next = tagged_reg;
        bset_next   = bset_reg;
        back_next   = back_reg;

        if (key_hit)
        begin
            tok_next.found = 1'b1;
            tok_next.fidx  = IW'(IDX);
            tok_next.ftag  = tagged_reg;
        end
        if (make)
        begin
            tok_next.found = 1'b1;
            tok_next.made  = 1'b1;
            tok_next.fidx  = IW'(IDX);
            tok_next.ftag  = 1'b0;
            kp_next        = tin.kp;
            kc_next        = tin.kc;
            tagged_next    = 1'b0;
            bset_next      = 1'b0;
            back_next      = '0;
        end
        if (idx_hit && (tin.op == OP_FIND || tin.op == OP_READ))
        begin
            tok_next.rback = bset_reg ? back_reg : '0;
        end
        if (idx_hit && tin.op == OP_SET_TAG)
        begin
            tagged_next = 1'b1;
        end
        if (idx_hit && tin.op == OP_SET_BACK && !bset_reg)
        begin
            bset_next = 1'b1;
            back_next = tin.data;
        end
        if (tin.valid && tin.op == OP_CLEAR)
        begin
            tagged_next = 1'b0;
            bset_next   = 1'b0;
            back_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= '0;
            tagged_reg <= 1'b0;
            bset_reg   <= 1'b0;
            back_reg   <= '0;
        end
        else
        begin
            tok_reg    <= tok_next;
            tagged_reg <= tagged_next;
            bset_reg   <= bset_next;
            back_reg   <= back_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kp_reg <= kp_next;
        kc_reg <= kc_next;
    end

endmodule

FILE: hw/rtl/multi_pattern_trie_matcher.sv
// ---------------------------------------------------------------------------
// multi_pattern_trie_matcher
// Pattern insertion and text search over a trie held in a chain of node
// cells; a token walks the chain one cell per cycle.
// ---------------------------------------------------------------------------
// channel  dir  handshake             payload
// in       in   in_valid/in_ready     command symbol final_char pattern_tag
//                                     start_position
// out      out  out_valid/out_ready   result_kind insert_status match_tag
//                                     match_end
// cfg      in   cfg_valid/cfg_ready   cfg_data (fold_case)
//
// One item at a time. Each trie lookup is one chain pass.
// Search item: (back links followed + 1) passes. Final pattern item: KMP
// compares, one pass per character, then, if added, a tag write and back-link
// steps, one per character. No clearing pass after reset; cfg always ready.
// A result waiting on out_ready stalls only the item that makes the next one.
// ---------------------------------------------------------------------------
module multi_pattern_trie_matcher
    import mptm_pkg::*;
#(
    parameter int MAX_NODES       = 256,
    parameter int MAX_PATTERN_LEN = 64,
    parameter int CHAR_BITS       = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [15:0] symbol,
    input  logic        final_char,
    input  logic [63:0] pattern_tag,
    input  logic [31:0] start_position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [1:0]  insert_status,
    output logic [63:0] match_tag,
    output logic [31:0] match_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam int IW   = $clog2(MAX_NODES);
    localparam int CNTW = $clog2(MAX_NODES + 1);
    localparam int CW   = CHAR_BITS;
    localparam int PIW  = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int LENW = $clog2(MAX_PATTERN_LEN + 2);
    localparam int TW   = $bits(tok_op_t) + 5 * IW + CW + 4;

    typedef struct packed {
        logic          valid;
        tok_op_t       op;
        logic [IW-1:0] kp;
        logic [CW-1:0] kc;
        logic [IW-1:0] ridx;
        logic [IW-1:0] data;
        logic          found;
        logic          made;
        logic [IW-1:0] fidx;
        logic          ftag;
        logic [IW-1:0] rback;
    } tok_t;

    state_t          state_reg, state_next;
    logic [LENW-1:0] plen_reg, plen_next;
    logic [LENW-1:0] len_reg, len_next;
    logic [LENW-1:0] i_reg, i_next;
    logic [LENW-1:0] k_reg, k_next;
    logic [IW-1:0]   node_reg, node_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [IW-1:0]   cur_reg, cur_next;
    logic [IW-1:0]   pend_reg, pend_next;
    logic            pv_reg, pv_next;
    logic [31:0]     pos_reg, pos_next;
    logic [CW-1:0]   sym_reg, sym_next;
    logic [63:0]     tag_in_reg, tag_in_next;
    logic            fold_reg;
    logic            res_kind_reg, res_kind_next;
    logic [1:0]      res_status_reg, res_status_next;
    logic [63:0]     res_tag_reg, res_tag_next;
    logic [31:0]     res_end_reg, res_end_next;
    logic            ret_srch_reg, ret_srch_next;

    logic            out_valid_reg;
    logic            result_kind_reg;
    logic [1:0]      insert_status_reg;
    logic [63:0]     match_tag_reg;
    logic [31:0]     match_end_reg;

    logic [CW-1:0]   chars_mem [MAX_PATTERN_LEN];
    logic [IW-1:0]   nodes_mem [MAX_PATTERN_LEN];
    logic [LENW-1:0] suf_mem   [MAX_PATTERN_LEN];
    logic [63:0]     tag_mem   [MAX_NODES];

    logic [CW-1:0]   chars_a_reg, chars_b_reg;
    logic [IW-1:0]   nodes_a_reg, nodes_b_reg;
    logic [LENW-1:0] suf_rd_reg;
    logic [63:0]     tag_rd_reg;

    logic [PIW-1:0]  chars_a_addr, chars_b_addr, nodes_a_addr, nodes_b_addr, suf_addr;
    logic            chars_we, nodes_we, suf_we, tag_we;
    logic [PIW-1:0]  chars_wa, nodes_wa, suf_wa;
    logic [CW-1:0]   chars_wd;
    logic [IW-1:0]   nodes_wd;
    logic [LENW-1:0] suf_wd;

    tok_t            tok_issue;
    tok_t            tok_ret;
    logic [TW-1:0]   chain [MAX_NODES+1];

    logic            in_acc;
    logic            emit_fire;
    logic            ret_find;
    logic [31:0]     sym_wide;
    logic [CW-1:0]   ch_in;
    logic [CW-1:0]   ch_fold;
    logic [LENW-1:0] len_new;
    logic [LENW-1:0] i_inc;
    logic [LENW-1:0] k_dec;
    logic [LENW-1:0] s_dec;
    logic            kmp_miss;
    logic            kmp_eq;
    logic            is_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    assign out_valid     = out_valid_reg;
    assign result_kind   = result_kind_reg;
    assign insert_status = insert_status_reg;
    assign match_tag     = match_tag_reg;
    assign match_end     = match_end_reg;

    assign sym_wide = {16'b0, symbol};
    assign ch_in    = sym_wide[CW-1:0];
    assign ch_fold  = (fold_reg && ch_in >= CW'(ASCII_UPPER_A) && ch_in <= CW'(ASCII_UPPER_Z))
                      ? ch_in + CW'(ASCII_CASE_OFS) : ch_in;
    assign len_new  = (plen_reg < LENW'(MAX_PATTERN_LEN)) ? plen_reg + LENW'(1)
                      : LENW'(MAX_PATTERN_LEN + 1);
    assign i_inc    = i_reg + LENW'(1);
    assign k_dec    = k_reg - LENW'(1);
    assign s_dec    = suf_rd_reg - LENW'(1);
    assign kmp_eq   = (chars_a_reg == chars_b_reg);
    assign kmp_miss = (k_reg != '0) && !kmp_eq;
    assign is_last  = (i_inc == len_reg);

    assign tok_ret  = tok_t'(chain[MAX_NODES]);
    assign ret_find = tok_ret.valid
                      && (tok_ret.op == OP_FIND || tok_ret.op == OP_FINDADD
                          || tok_ret.op == OP_READ);

    // node chain
    assign chain[0] = tok_issue;

    for (genvar g = 0; g < MAX_NODES; g++)
    begin : g_cell
        mptm_cell #(
            .IDX  (g),
            .IW   (IW),
            .CNTW (CNTW),
            .CW   (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .node_count (count_reg),
            .tok_in     (chain[g]),
            .tok_out    (chain[g+1])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (command)
                        CMD_PATTERN:
                        begin
                            if (final_char)
                            begin
                                if (len_new > LENW'(MAX_PATTERN_LEN))
                                    state_next = S_EMIT;
                                else if (len_new == LENW'(1))
                                    state_next = S_WALK_RD;
                                else
                                    state_next = S_KMP_RD;
                            end
                        end
                        CMD_SEARCH:
                            state_next = S_SRCH_ISSUE;
                        CMD_EOT:
                        begin
                            if (pv_reg)
                                state_next = S_EOT_ISSUE;
                        end
                        CMD_CLEAR:
                            state_next = S_CLR;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_KMP_RD:
                state_next = S_KMP_CMP;
            S_KMP_CMP:
            begin
                if (kmp_miss || !is_last)
                    state_next = S_KMP_RD;
                else
                    state_next = S_WALK_RD;
            end
            S_WALK_RD:
                state_next = S_WALK_ISSUE;
            S_WALK_ISSUE:
                state_next = S_WALK_WAIT;
            S_WALK_WAIT:
            begin
                if (ret_find)
                begin
                    if (!tok_ret.found)
                        state_next = S_EMIT;
                    else if (is_last && tok_ret.ftag)
                        state_next = S_EMIT;
                    else if (is_last)
                        state_next = S_TAG_ISSUE;
                    else
                        state_next = S_WALK_RD;
                end
            end
            S_TAG_ISSUE:
                state_next = S_BACK_RD1;
            S_BACK_RD1:
                state_next = S_BACK_RD2;
            S_BACK_RD2:
                state_next = S_BACK_ISSUE;
            S_BACK_ISSUE:
                state_next = is_last ? S_EMIT : S_BACK_RD1;
            S_SRCH_ISSUE:
                state_next = S_SRCH_WAIT;
            S_SRCH_WAIT:
            begin
                if (ret_find)
                begin
                    if (tok_ret.found)
                        state_next = S_IDLE;
                    else if (pv_reg)
                        state_next = S_EMIT;
                    else if (cur_reg != '0)
                        state_next = S_SRCH_ISSUE;
                    else
                        state_next = S_IDLE;
                end
            end
            S_EOT_ISSUE:
                state_next = S_EOT_WAIT;
            S_EOT_WAIT:
            begin
                if (ret_find)
                    state_next = S_EMIT;
            end
            S_CLR:
                state_next = S_IDLE;
            S_EMIT:
            begin
                if (emit_fire)
                    state_next = ret_srch_reg ? S_SRCH_ISSUE : S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath, memory ports and token issue
    always_comb
    begin
        plen_next       = plen_reg;
        len_next        = len_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        node_next       = node_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        pv_next         = pv_reg;
        pos_next        = pos_reg;
        sym_next        = sym_reg;
        tag_in_next     = tag_in_reg;
        res_kind_next   = res_kind_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_end_next    = res_end_reg;
        ret_srch_next   = ret_srch_reg;

        chars_a_addr = i_reg[PIW-1:0];
        chars_b_addr = k_reg[PIW-1:0];
        nodes_a_addr = i_reg[PIW-1:0];
        nodes_b_addr = s_dec[PIW-1:0];
        suf_addr     = k_dec[PIW-1:0];
        chars_we     = 1'b0;
        chars_wa     = plen_reg[PIW-1:0];
        chars_wd     = ch_in;
        nodes_we     = 1'b0;
        nodes_wa     = i_reg[PIW-1:0];
        nodes_wd     = tok_ret.fidx;
        suf_we       = 1'b0;
        suf_wa       = i_reg[PIW-1:0];
        suf_wd       = '0;
        tag_we       = 1'b0;
        tok_issue    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (command)
                        CMD_PATTERN:
                        begin
                            plen_next = len_new;
                            if (plen_reg < LENW'(MAX_PATTERN_LEN))
                                chars_we = 1'b1;
                            if (final_char)
                            begin
                                plen_next     = '0;
                                len_next      = len_new;
                                tag_in_next   = pattern_tag;
                                node_next     = '0;
                                k_next        = '0;
                                i_next        = (len_new == LENW'(1)) ? '0 : LENW'(1);
                                res_kind_next   = KIND_INSERT;
                                res_status_next = ST_TOO_LONG;
                                res_tag_next    = '0;
                                res_end_next    = '0;
                                ret_srch_next   = 1'b0;
                                suf_we        = 1'b1;
                                suf_wa        = '0;
                            end
                        end
                        CMD_SEARCH:
                            sym_next = ch_fold;
                        CMD_RESTART:
                        begin
                            pos_next = start_position;
                            cur_next = '0;
                            pv_next  = 1'b0;
                        end
                        CMD_CLEAR:
                        begin
                            count_next = CNTW'(1);
                            cur_next   = '0;
                            pv_next    = 1'b0;
                        end
                        default:
                            pos_next = pos_reg;
                    endcase
                end
            end
            S_KMP_CMP:
            begin
                if (kmp_miss)
                begin
                    k_next = suf_rd_reg;
                end
                else
                begin
                    k_next = kmp_eq ? k_reg + LENW'(1) : k_reg;
                    suf_we = 1'b1;
                    suf_wd = kmp_eq ? k_reg + LENW'(1) : k_reg;
                    i_next = is_last ? '0 : i_inc;
                end
            end
            S_WALK_ISSUE:
            begin
                tok_issue.valid = 1'b1;
                tok_issue.op    = OP_FINDADD;
                tok_issue.kp    = node_reg;
                tok_issue.kc    = chars_a_reg;
            end
            S_WALK_WAIT:
            begin
                if (ret_find)
                begin
                    res_kind_next = KIND_INSERT;
                    res_tag_next  = '0;
                    res_end_next  = '0;
                    ret_srch_next = 1'b0;
                    if (!tok_ret.found)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNTW'(tok_ret.made);
                        node_next  = tok_ret.fidx;
                        nodes_we   = 1'b1;
                        res_status_next = ST_DUP;
                        if (!is_last)
                            i_next = i_inc;
                    end
                end
            end
            S_TAG_ISSUE:
            begin
                tok_issue.valid = 1'b1;
                tok_issue.op    = OP_SET_TAG;
                tok_issue.ridx  = node_reg;
                tag_we          = 1'b1;
                i_next          = '0;
            end
            S_BACK_RD1:
                suf_addr = i_reg[PIW-1:0];
            S_BACK_RD2:
            begin
                node_next = nodes_a_reg;
                k_next    = suf_rd_reg;
            end
            S_BACK_ISSUE:
            begin
                tok_issue.valid = 1'b1;
                tok_issue.op    = OP_SET_BACK;
                tok_issue.ridx  = node_reg;
                tok_issue.data  = (k_reg != '0) ? nodes_b_reg : '0;
                i_next          = i_inc;
                res_status_next = ST_ADDED;
            end
            S_SRCH_ISSUE:
            begin
                tok_issue.valid = 1'b1;
                tok_issue.op    = OP_FIND;
                tok_issue.kp    = cur_reg;
                tok_issue.kc    = sym_reg;
                tok_issue.ridx  = cur_reg;
            end
            S_SRCH_WAIT:
            begin
                if (ret_find)
                begin
                    if (tok_ret.found)
                    begin
                        cur_next = tok_ret.fidx;
                        pos_next = pos_reg + 32'd1;
                        if (tok_ret.ftag)
                        begin
                            pend_next = tok_ret.fidx;
                            pv_next   = 1'b1;
                        end
                    end
                    else if (pv_reg)
                    begin
                        res_kind_next   = KIND_MATCH;
                        res_status_next = ST_ADDED;
                        res_tag_next    = tag_rd_reg;
                        res_end_next    = pos_reg;
                        ret_srch_next   = 1'b1;
                        pv_next         = 1'b0;
                        cur_next        = tok_ret.rback;
                    end
                    else if (cur_reg != '0)
                    begin
                        cur_next = tok_ret.rback;
                    end
                    else
                    begin
                        pos_next = pos_reg + 32'd1;
                    end
                end
            end
            S_EOT_ISSUE:
            begin
                tok_issue.valid = 1'b1;
                tok_issue.op    = OP_READ;
                tok_issue.ridx  = cur_reg;
            end
            S_EOT_WAIT:
            begin
                if (ret_find)
                begin
                    res_kind_next   = KIND_MATCH;
                    res_status_next = ST_ADDED;
                    res_tag_next    = tag_rd_reg;
                    res_end_next    = pos_reg;
                    ret_srch_next   = 1'b0;
                    pv_next         = 1'b0;
                    cur_next        = tok_ret.rback;
                end
            end
            S_CLR:
            begin
                tok_issue.valid = 1'b1;
                tok_issue.op    = OP_CLEAR;
            end
            default:
                tok_issue = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            plen_reg      <= '0;
            count_reg     <= CNTW'(1);
            cur_reg       <= '0;
            pv_reg        <= 1'b0;
            pos_reg       <= '0;
            fold_reg      <= 1'b0;
            ret_srch_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            plen_reg     <= plen_next;
            count_reg    <= count_next;
            cur_reg      <= cur_next;
            pv_reg       <= pv_next;
            pos_reg      <= pos_next;
            ret_srch_reg <= ret_srch_next;
            if (cfg_valid && cfg_ready)
                fold_reg <= cfg_data;
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        i_reg          <= i_next;
        k_reg          <= k_next;
        node_reg       <= node_next;
        pend_reg       <= pend_next;
        sym_reg        <= sym_next;
        tag_in_reg     <= tag_in_next;
        res_kind_reg   <= res_kind_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_end_reg    <= res_end_next;
        if (emit_fire)
        begin
            result_kind_reg   <= res_kind_reg;
            insert_status_reg <= res_status_reg;
            match_tag_reg     <= res_tag_reg;
            match_end_reg     <= res_end_reg;
        end
    end

    // pattern buffers and tag words
    always_ff @(posedge clk)
    begin
        if (chars_we)
            chars_mem[chars_wa] <= chars_wd;
        chars_a_reg <= chars_mem[chars_a_addr];
        chars_b_reg <= chars_mem[chars_b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (nodes_we)
            nodes_mem[nodes_wa] <= nodes_wd;
        nodes_a_reg <= nodes_mem[nodes_a_addr];
        nodes_b_reg <= nodes_mem[nodes_b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (suf_we)
            suf_mem[suf_wa] <= suf_wd;
        suf_rd_reg <= suf_mem[suf_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[node_reg] <= tag_in_reg;
        tag_rd_reg <= tag_mem[pend_reg];
    end

`ifndef SYNTHESIS
    a_root_never_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> pend_reg != '0)
        else $error("pending match on root node");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("result not presented after emit");

    a_clear_resets_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && command == CMD_CLEAR) |=> count_reg == CNTW'(1))
        else $error("node count not reset by clear");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_WAIT && ret_find && tok_ret.made)
        |-> count_reg < CNTW'(MAX_NODES))
        else $error("node made beyond table size");
`endif

endmodule

FILE: sim/multi_pattern_trie_matcher_test.sv
// ---------------------------------------------------------------------------
// multi_pattern_trie_matcher_test
// Self-checking test of the trie matcher. A directed table, long-pattern
// bursts (table full, too long) and random pattern/search traffic under both
// fold_case settings are checked against a behavioral trie model, with
// random idling on both channels and one long output stall.
// ---------------------------------------------------------------------------
module multi_pattern_trie_matcher_test;
    import mptm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NODES      = 256;
    localparam int          PAT_MAX    = 64;
    localparam int          SETTLE     = 20000;
    localparam longint      LIMIT      = 40_000_000;
    localparam int          PHASE_ITEMS = 250;
    localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

    typedef struct {
        logic        kind;
        logic [1:0]  status;
        logic [63:0] tag;
        logic [31:0] end_pos;
    } result_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [15:0] sym;
        logic        fin;
        logic [63:0] tag;
        logic [31:0] start;
        bit          typed;
        logic [1:0]  status;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [15:0] symbol;
    logic        final_char;
    logic [63:0] pattern_tag;
    logic [31:0] start_position;
    logic        out_valid;
    logic        out_ready;
    logic        result_kind;
    logic [1:0]  insert_status;
    logic [63:0] match_tag;
    logic [31:0] match_end;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    multi_pattern_trie_matcher dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .symbol         (symbol),
        .final_char     (final_char),
        .pattern_tag    (pattern_tag),
        .start_position (start_position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .insert_status  (insert_status),
        .match_tag      (match_tag),
        .match_end      (match_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // trie model
    int          trie_parent [NODES];
    logic [15:0] trie_chr    [NODES];
    bit          trie_tagged [NODES];
    logic [63:0] trie_tag    [NODES];
    bit          trie_back_ok[NODES];
    int          trie_back   [NODES];
    int          trie_size;
    logic [15:0] pat_chr [PAT_MAX];
    int          pat_node[PAT_MAX];
    int          pat_sfx [PAT_MAX];
    int          pat_len;
    int          walk_node;
    bit          pend_v;
    int          pend_node;
    logic [31:0] text_pos;
    bit          fold;

    result_t     results_due[$];
    int          errors;
    int          n_items;
    int          n_inserts;
    int          n_matches;
    longint      cycles;
    bit          quiet;
    int          hold_cnt;
    row_t        dir_rows[26];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void clear_trie();
        for (int i = 0; i < NODES; i++)
        begin
            trie_tagged[i]  = 1'b0;
            trie_back_ok[i] = 1'b0;
            trie_back[i]    = 0;
        end
        trie_size = 1;
        walk_node = 0;
        pend_v    = 1'b0;
    endfunction

    function automatic bit find_child(input int parent, input logic [15:0] ch,
                                      output int child);
        child = 0;
        for (int n = 1; n < trie_size; n++)
        begin
            if (trie_parent[n] == parent && trie_chr[n] == ch)
            begin
                child = n;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int back_of(input int n);
        return trie_back_ok[n] ? trie_back[n] : 0;
    endfunction

    function automatic logic [1:0] add_pattern(input logic [63:0] tag);
        int len;
        int k;
        int node;
        int child;
        len     = pat_len;
        pat_len = 0;
        k       = 0;
        node    = 0;
        if (len > PAT_MAX || len == 0)
            return ST_TOO_LONG;
        pat_sfx[0] = 0;
        for (int i = 1; i < len; i++)
        begin
            while (k > 0 && pat_chr[i] != pat_chr[k])
                k = pat_sfx[k - 1];
            if (pat_chr[i] == pat_chr[k])
                k++;
            pat_sfx[i] = k;
        end
        for (int i = 0; i < len; i++)
        begin
            if (!find_child(node, pat_chr[i], child))
            begin
                if (trie_size >= NODES)
                    return ST_FULL;
                child = trie_size++;
                trie_parent[child]  = node;
                trie_chr[child]     = pat_chr[i];
                trie_tagged[child]  = 1'b0;
                trie_back_ok[child] = 1'b0;
                trie_back[child]    = 0;
            end
            node = child;
            pat_node[i] = node;
        end
        if (trie_tagged[node])
            return ST_DUP;
        trie_tagged[node] = 1'b1;
        trie_tag[node]    = tag;
        for (int i = 0; i < len; i++)
        begin
            if (!trie_back_ok[pat_node[i]])
            begin
                trie_back[pat_node[i]]    = (pat_sfx[i] != 0) ? pat_node[pat_sfx[i] - 1] : 0;
                trie_back_ok[pat_node[i]] = 1'b1;
            end
        end
        return ST_ADDED;
    endfunction

    function automatic result_t match_report();
        result_t r;
        r.kind    = KIND_MATCH;
        r.status  = ST_ADDED;
        r.tag     = trie_tag[pend_node];
        r.end_pos = text_pos;
        return r;
    endfunction

    task automatic predict_item(input logic [2:0] c, input logic [15:0] s,
                                input logic f, input logic [63:0] t,
                                input logic [31:0] st, output bit got,
                                output result_t r);
        logic [15:0] ch;
        int          child;
        bit          done;
        got = 1'b0;
        r   = '{KIND_INSERT, ST_ADDED, 64'd0, 32'd0};
        ch  = s;
        case (c)
            CMD_PATTERN:
            begin
                if (pat_len < PAT_MAX)
                    pat_chr[pat_len++] = s;
                else
                    pat_len = PAT_MAX + 1;
                if (f)
                begin
                    got      = 1'b1;
                    r.status = add_pattern(t);
                end
            end
            CMD_SEARCH:
            begin
                if (fold && ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z)
                    ch = ch + ASCII_CASE_OFS;
                done = 1'b0;
                for (int g = 0; g < 2 * NODES + 2 && !done; g++)
                begin
                    if (find_child(walk_node, ch, child))
                    begin
                        walk_node = child;
                        if (trie_tagged[child])
                        begin
                            pend_v    = 1'b1;
                            pend_node = child;
                        end
                        text_pos++;
                        done = 1'b1;
                    end
                    else if (pend_v)
                    begin
                        r         = match_report();
                        got       = 1'b1;
                        pend_v    = 1'b0;
                        walk_node = back_of(walk_node);
                    end
                    else if (walk_node != 0)
                        walk_node = back_of(walk_node);
                    else
                    begin
                        text_pos++;
                        done = 1'b1;
                    end
                end
                if (!done)
                    text_pos++;
            end
            CMD_EOT:
            begin
                if (pend_v)
                begin
                    r         = match_report();
                    got       = 1'b1;
                    pend_v    = 1'b0;
                    walk_node = back_of(walk_node);
                end
            end
            CMD_RESTART:
            begin
                text_pos  = st;
                walk_node = 0;
                pend_v    = 1'b0;
            end
            CMD_CLEAR:
                clear_trie();
            default:
                ;
        endcase
    endtask

    task automatic send_item(input logic [2:0] c, input logic [15:0] s,
                             input logic f, input logic [63:0] t,
                             input logic [31:0] st, input bit typed = 1'b0,
                             input logic [1:0] typed_status = ST_ADDED);
        bit      got;
        result_t r;
        if (!quiet && $urandom_range(0, 99) < 10)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        command        = c;
        symbol         = s;
        final_char     = f;
        pattern_tag    = t;
        start_position = st;
        in_valid       = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_item(c, s, f, t, st, got, r);
        if (typed)
            r = '{KIND_INSERT, typed_status, 64'd0, 32'd0};
        if (got)
            results_due.push_back(r);
        if (c <= CMD_CLEAR)
            n_items++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_fold(input bit v);
        drain();
        cfg_data  = v;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        fold = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'h0061;
            3, 4:    return 16'h0062;
            5:       return 16'h0063;
            6:       return 16'h0041;
            7:       return 16'h0042;
            8:       return 16'h0043;
            default: return 16'($urandom);
        endcase
    endfunction

    // long patterns of distinct characters fill the node store; a too-long pattern and a clear follow
    task automatic fill_table();
        logic [1:0] want;
        for (int p = 0; p < 4; p++)
        begin
            want = (p == 3) ? ST_FULL : ST_ADDED;
            for (int j = 0; j < PAT_MAX; j++)
                send_item(CMD_PATTERN, 16'(16'h1000 + p * PAT_MAX + j), j == PAT_MAX - 1,
                          {$urandom, $urandom}, 32'd0, j == PAT_MAX - 1, want);
        end
        for (int j = 0; j <= PAT_MAX; j++)
            send_item(CMD_PATTERN, 16'h0061, j == PAT_MAX, 64'd0, 32'd0,
                      j == PAT_MAX, ST_TOO_LONG);
        send_item(CMD_CLEAR, 16'd0, 1'b0, 64'd0, 32'd0);
    endtask

    task automatic random_phase(input bit pressure, input bit calm);
        int  start_cnt;
        int  len;
        int  pick;
        start_cnt = n_items;
        while (n_items - start_cnt < PHASE_ITEMS)
        begin
            if (pressure && n_items - start_cnt == 60)
                hold_cnt = 3000;
            quiet = calm && (n_items - start_cnt) > 50 && (n_items - start_cnt) < 200;
            pick  = $urandom_range(0, 99);
            if (pick < 30)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
                for (int j = 0; j < len; j++)
                    send_item(CMD_PATTERN, pick_char(), j == len - 1, {$urandom, $urandom},
                              $urandom);
            end
            else if (pick < 82)
            begin
                len = $urandom_range(3, 12);
                for (int j = 0; j < len; j++)
                    send_item(CMD_SEARCH, pick_char(), $urandom_range(0, 1),
                              {$urandom, $urandom}, $urandom);
                if ($urandom_range(0, 1))
                    send_item(CMD_EOT, 16'($urandom), $urandom_range(0, 1),
                              {$urandom, $urandom}, $urandom);
            end
            else if (pick < 90)
                send_item(CMD_RESTART, 16'($urandom), $urandom_range(0, 1),
                          {$urandom, $urandom},
                          $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3));
            else if (pick < 93)
                send_item(CMD_CLEAR, 16'($urandom), $urandom_range(0, 1),
                          {$urandom, $urandom}, $urandom);
            else if (pick < 96)
                send_item(CMD_EOT, 16'($urandom), 1'b0, 64'd0, 32'd0);
            else
                send_item(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), 16'($urandom),
                          $urandom_range(0, 1), {$urandom, $urandom}, $urandom);
        end
        quiet = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cnt > 0)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt - 1;
        end
        else
            out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end

    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result: kind %0d status %0d tag %h end %h",
                       result_kind, insert_status, match_tag, match_end);
                errors++;
            end
            else
            begin
                r = results_due.pop_front();
                if (r.kind == KIND_MATCH)
                    n_matches++;
                else
                    n_inserts++;
                if (result_kind !== r.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", r.kind, result_kind);
                    errors++;
                end
                if (insert_status !== r.status)
                begin
                    $error("insert_status: expected %0d, got %0d", r.status, insert_status);
                    errors++;
                end
                if (match_tag !== r.tag)
                begin
                    $error("match_tag: expected %h, got %h", r.tag, match_tag);
                    errors++;
                end
                if (match_end !== r.end_pos)
                begin
                    $error("match_end: expected %h, got %h", r.end_pos, match_end);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors         = 0;
        n_items        = 0;
        n_inserts      = 0;
        n_matches      = 0;
        cycles         = 0;
        quiet          = 1'b0;
        hold_cnt       = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_EOT;
        symbol         = 16'd0;
        final_char     = 1'b0;
        pattern_tag    = 64'd0;
        start_position = 32'd0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        clear_trie();
        pat_len  = 0;
        text_pos = 32'd0;
        fold     = 1'b0;

        dir_rows = '{
            '{CMD_EOT,       16'h0000, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_PATTERN,   16'h0068, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_PATTERN,   16'h0065, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b1, ST_ADDED},
            '{CMD_PATTERN,   16'h0068, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_PATTERN,   16'h0065, 1'b1, 64'd0,                  32'd0, 1'b1, ST_DUP},
            '{CMD_PATTERN,   16'h0065, 1'b1, 64'd0,                  32'd0, 1'b1, ST_ADDED},
            '{CMD_PATTERN,   16'h0061, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_PATTERN,   16'h0062, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_PATTERN,   16'h0061, 1'b1, 64'h5555_5555_5555_5555, 32'd0, 1'b1, ST_ADDED},
            '{CMD_PATTERN,   16'hFFFF, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0, 1'b1, ST_ADDED},
            '{CMD_RESTART,   16'h0000, 1'b0, 64'd0,          32'hFFFF_FFFE, 1'b0, ST_ADDED},
            '{CMD_SEARCH,    16'h0048, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_SEARCH,    16'h0068, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_SEARCH,    16'h0065, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_SEARCH,    16'h0078, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_SEARCH,    16'h0061, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_SEARCH,    16'h0062, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_SEARCH,    16'h0061, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_SEARCH,    16'h0062, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_SEARCH,    16'h0061, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_EOT,       16'h0000, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_EOT,       16'h0000, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_UNUSED_LO, 16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ST_ADDED},
            '{CMD_UNUSED_HI, 16'h0000, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_SEARCH,    16'hFFFF, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED},
            '{CMD_EOT,       16'h0000, 1'b0, 64'd0,                  32'd0, 1'b0, ST_ADDED}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_fold(1'b0);
        foreach (dir_rows[i])
            send_item(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].fin, dir_rows[i].tag,
                      dir_rows[i].start, dir_rows[i].typed, dir_rows[i].status);
        fill_table();

        write_fold(1'b1);
        random_phase(1'b1, 1'b0);
        write_fold(1'b0);
        random_phase(1'b0, 1'b1);
        write_fold(1'b1);
        random_phase(1'b0, 1'b0);
        write_fold(1'b0);
        random_phase(1'b0, 1'b0);

        drain();
        if (results_due.size() != 0)
        begin
            $error("%0d expected results never arrived", results_due.size());
            errors++;
        end
        $display("Covered %0d items: %0d insertion reports, %0d match reports,",
                 n_items, n_inserts, n_matches);
        $display("both case-fold settings, table full, too-long and output back-pressure.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/mptm_pkg.sv
hw/rtl/mptm_cell.sv
hw/rtl/multi_pattern_trie_matcher.sv
sim/multi_pattern_trie_matcher_test.sv
